// ===== design/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

    // Default table geometry
    localparam int PATTERN_SLOTS_DEF = 8;
    localparam int PULSES_DEF        = 16;

    // Field widths
    localparam int OPCODE_W = 3;
    localparam int ID_W     = 4;
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 16;
    localparam int CNT_W    = 5;
    localparam int REP_W    = 8;
    localparam int PRIO_W   = 8;

    localparam logic [REP_W-1:0]  REPEAT_FOREVER    = 8'd255;
    localparam logic [TIME_W-1:0] START_DELAY_RESET = 16'd100;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_WR_PULSE  = 3'd3,
        OP_WR_HEADER = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ID_W-1:0]     pattern_id;
        logic [SLOT_W-1:0]   pulse_slot;
        logic [TIME_W-1:0]   on_time_ms;
        logic [TIME_W-1:0]   off_time_ms;
        logic [CNT_W-1:0]    pulse_count;
        logic [REP_W-1:0]    repeat_limit;
        logic [PRIO_W-1:0]   pattern_priority;
    } t_item;

    typedef struct packed {
        logic              led_on;
        logic              busy_res;
        logic [ID_W-1:0]   current_pattern;
        logic [SLOT_W-1:0] pulse_position;
        logic [REP_W-1:0]  repeats_done;
        logic              start_status;
        logic              finished;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] off_ms;
    } t_pulse;

    typedef struct packed {
        logic [CNT_W-1:0]  len;
        logic [REP_W-1:0]  rep;
        logic [PRIO_W-1:0] rank;
    } t_header;

    // Table write request from the sequencer core
    typedef struct packed {
        logic              pulse_we;
        logic              hdr_we;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        t_pulse            pulse;
        t_header           header;
    } t_wr_cmd;

    // Index width for a table of n entries, never below one bit
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== design/lps_if.sv =====
`default_nettype none

// Command channel
interface lps_item_if;
    logic                            valid;
    logic                            ready;
    logic [lps_pkg::OPCODE_W-1:0]    opcode;
    logic [lps_pkg::ID_W-1:0]        pattern_id;
    logic [lps_pkg::SLOT_W-1:0]      pulse_slot;
    logic [lps_pkg::TIME_W-1:0]      on_time_ms;
    logic [lps_pkg::TIME_W-1:0]      off_time_ms;
    logic [lps_pkg::CNT_W-1:0]       pulse_count;
    logic [lps_pkg::REP_W-1:0]       repeat_limit;
    logic [lps_pkg::PRIO_W-1:0]      pattern_priority;

    modport source (
        output valid, opcode, pattern_id, pulse_slot, on_time_ms, off_time_ms,
               pulse_count, repeat_limit, pattern_priority,
        input  ready
    );
    modport sink (
        input  valid, opcode, pattern_id, pulse_slot, on_time_ms, off_time_ms,
               pulse_count, repeat_limit, pattern_priority,
        output ready
    );
endinterface

// Status channel
interface lps_res_if;
    logic                          valid;
    logic                          ready;
    logic                          led_on;
    logic                          busy_res;
    logic [lps_pkg::ID_W-1:0]      current_pattern;
    logic [lps_pkg::SLOT_W-1:0]    pulse_position;
    logic [lps_pkg::REP_W-1:0]     repeats_done;
    logic                          start_status;
    logic                          finished;

    modport source (
        output valid, led_on, busy_res, current_pattern, pulse_position,
               repeats_done, start_status, finished,
        input  ready
    );
    modport sink (
        input  valid, led_on, busy_res, current_pattern, pulse_position,
               repeats_done, start_status, finished,
        output ready
    );
endinterface

// Start delay register write channel
interface lps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lps_pkg::TIME_W-1:0]    start_delay_ms;

    modport source (output valid, start_delay_ms, input ready);
    modport sink   (input valid, start_delay_ms, output ready);
endinterface

`default_nettype wire

// ===== design/lps_pulse_mem.sv =====
`default_nettype none

module lps_pulse_mem #(
    parameter int PATTERN_SLOTS      = lps_pkg::PATTERN_SLOTS_DEF,
    parameter int PULSES_PER_PATTERN = lps_pkg::PULSES_DEF
) (
    input  wire logic                                        i_clk,
    input  wire lps_pkg::t_wr_cmd                            i_wr,
    input  wire logic [lps_pkg::idx_width(PATTERN_SLOTS)-1:0]      i_rd_pat,
    input  wire logic [lps_pkg::idx_width(PULSES_PER_PATTERN)-1:0] i_rd_pulse,
    output lps_pkg::t_pulse                                  o_rd
);

    localparam int DEPTH = PATTERN_SLOTS * PULSES_PER_PATTERN;
    localparam int AW    = lps_pkg::idx_width(DEPTH);

    lps_pkg::t_pulse r_mem [DEPTH];
    lps_pkg::t_pulse r_rd;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Flattened pattern/pulse addresses
    assign wr_addr = AW'(32'(i_wr.id) * PULSES_PER_PATTERN + 32'(i_wr.slot));
    assign rd_addr = AW'(32'(i_rd_pat) * PULSES_PER_PATTERN + 32'(i_rd_pulse));

    // Write port, registered read with write forwarding
    always_ff @(posedge i_clk) begin
        if (i_wr.pulse_we) begin
            r_mem[wr_addr] <= i_wr.pulse;
        end
        if (i_wr.pulse_we && (wr_addr == rd_addr)) begin
            r_rd <= i_wr.pulse;
        end else begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

// ===== design/lps_hdr_mem.sv =====
`default_nettype none

module lps_hdr_mem #(
    parameter int PATTERN_SLOTS = lps_pkg::PATTERN_SLOTS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire lps_pkg::t_wr_cmd                       i_wr,
    input  wire logic [lps_pkg::idx_width(PATTERN_SLOTS)-1:0] i_rd_a,
    input  wire logic                                   i_rd_b_en,
    input  wire logic [lps_pkg::ID_W-1:0]               i_rd_b,
    output lps_pkg::t_header                            o_rd_a,
    output logic [lps_pkg::PRIO_W-1:0]                  o_rank_b
);

    localparam int SW = lps_pkg::idx_width(PATTERN_SLOTS);

    lps_pkg::t_header            r_mem [PATTERN_SLOTS];
    lps_pkg::t_header            r_rd_a;
    logic [lps_pkg::PRIO_W-1:0]  r_rank_b;
    logic [SW-1:0]               wr_idx;
    logic [SW-1:0]               rd_b_idx;

    assign wr_idx   = SW'(i_wr.id);
    assign rd_b_idx = SW'(i_rd_b);

    // Port A follows the running pattern every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.hdr_we) begin
            r_mem[wr_idx] <= i_wr.header;
        end
        if (i_wr.hdr_we && (wr_idx == i_rd_a)) begin
            r_rd_a <= i_wr.header;
        end else begin
            r_rd_a <= r_mem[i_rd_a];
        end
    end

    // Port B fetches the requested pattern's rank as a beat is taken
    always_ff @(posedge i_clk) begin
        if (i_rd_b_en) begin
            if (i_wr.hdr_we && (i_wr.id == i_rd_b)) begin
                r_rank_b <= i_wr.header.rank;
            end else begin
                r_rank_b <= r_mem[rd_b_idx].rank;
            end
        end
    end

    assign o_rd_a   = r_rd_a;
    assign o_rank_b = r_rank_b;

endmodule

`default_nettype wire

// ===== design/lps_core.sv =====
`default_nettype none

module lps_core #(
    parameter int PATTERN_SLOTS      = lps_pkg::PATTERN_SLOTS_DEF,
    parameter int PULSES_PER_PATTERN = lps_pkg::PULSES_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_fire,
    input  wire lps_pkg::t_item                         i_item,
    input  wire logic [lps_pkg::TIME_W-1:0]             i_start_delay,
    input  wire lps_pkg::t_pulse                        i_pulse,
    input  wire lps_pkg::t_header                       i_hdr_cur,
    input  wire logic [lps_pkg::PRIO_W-1:0]             i_pid_rank,
    output lps_pkg::t_wr_cmd                            o_wr,
    output lps_pkg::t_result                            o_res,
    output logic [lps_pkg::idx_width(PATTERN_SLOTS)-1:0]      o_rd_pat,
    output logic [lps_pkg::idx_width(PULSES_PER_PATTERN)-1:0] o_rd_pulse
);

    localparam int SW = lps_pkg::idx_width(PATTERN_SLOTS);
    localparam int PW = lps_pkg::idx_width(PULSES_PER_PATTERN);

    // Sequencer state
    logic                        r_act_vld, n_act_vld;
    logic [SW-1:0]               r_act_idx, n_act_idx;
    logic                        r_phase_on, n_phase_on;
    logic [PW-1:0]               r_pulse_idx, n_pulse_idx;
    logic [lps_pkg::REP_W-1:0]   r_rep_cnt, n_rep_cnt;
    logic [lps_pkg::TIME_W-1:0]  r_rem, n_rem;
    logic                        r_run, n_run;
    logic                        r_led, n_led;

    logic                        pid_vld;
    logic [SW-1:0]               pid_idx;
    logic                        same_pat;
    logic [PW:0]                 len_c;
    logic [PW:0]                 pi_new;
    logic [lps_pkg::REP_W-1:0]   rep_inc;
    logic                        armed;
    logic                        status;
    logic                        done;

    assign pid_vld  = 32'(i_item.pattern_id) < PATTERN_SLOTS;
    assign pid_idx  = SW'(i_item.pattern_id);
    // "No pattern" on both sides counts as a match
    assign same_pat = pid_vld ? (r_act_vld && (r_act_idx == pid_idx)) : !r_act_vld;
    assign rep_inc  = r_rep_cnt + 1'b1;

    // Pulse count clamped to 1..PULSES_PER_PATTERN
    always_comb begin
        if (i_hdr_cur.len == '0) begin
            len_c = (PW+1)'(1);
        end else if (32'(i_hdr_cur.len) > PULSES_PER_PATTERN) begin
            len_c = (PW+1)'(PULSES_PER_PATTERN);
        end else begin
            len_c = (PW+1)'(i_hdr_cur.len);
        end
    end

    // Next state
    always_comb begin
        n_act_vld   = r_act_vld;
        n_act_idx   = r_act_idx;
        n_phase_on  = r_phase_on;
        n_pulse_idx = r_pulse_idx;
        n_rep_cnt   = r_rep_cnt;
        n_rem       = r_rem;
        n_run       = r_run;
        n_led       = r_led;
        armed       = 1'b0;
        pi_new      = {1'b0, r_pulse_idx};
        status      = 1'b0;
        done        = 1'b0;

        o_wr             = '0;
        o_wr.id          = i_item.pattern_id;
        o_wr.slot        = i_item.pulse_slot;
        o_wr.pulse.on_ms  = i_item.on_time_ms;
        o_wr.pulse.off_ms = i_item.off_time_ms;
        o_wr.header.len  = i_item.pulse_count;
        o_wr.header.rep  = i_item.repeat_limit;
        o_wr.header.rank = i_item.pattern_priority;

        if (i_fire) begin
            case (lps_pkg::t_opcode'(i_item.opcode))
                lps_pkg::OP_TICK: begin
                    if (r_run) begin
                        if (r_rem <= lps_pkg::TIME_W'(1)) begin
                            n_rem = '0;
                            n_run = 1'b0;
                            if (r_act_vld) begin
                                // play the next on or off phase
                                if (!r_phase_on && (i_pulse.on_ms != '0)) begin
                                    n_led      = 1'b1;
                                    n_rem      = i_pulse.on_ms;
                                    n_run      = 1'b1;
                                    armed      = 1'b1;
                                    n_phase_on = 1'b1;
                                end else begin
                                    if (i_pulse.off_ms != '0) begin
                                        n_led = 1'b0;
                                        n_rem = i_pulse.off_ms;
                                        n_run = 1'b1;
                                        armed = 1'b1;
                                    end
                                    n_phase_on = 1'b0;
                                    pi_new     = {1'b0, r_pulse_idx} + 1'b1;
                                end
                                n_pulse_idx = pi_new[PW-1:0];
                                // end of one pass over the pulses
                                if (pi_new >= len_c) begin
                                    n_pulse_idx = '0;
                                    if (i_hdr_cur.rep != lps_pkg::REPEAT_FOREVER) begin
                                        n_rep_cnt = rep_inc;
                                        if (rep_inc >= i_hdr_cur.rep) begin
                                            n_rep_cnt = '0;
                                            n_act_vld = 1'b0;
                                            done      = 1'b1;
                                        end
                                    end
                                end
                                // both phases empty: keep walking next tick
                                if (n_act_vld && !armed) begin
                                    n_rem = lps_pkg::TIME_W'(1);
                                    n_run = 1'b1;
                                end
                            end
                        end else begin
                            n_rem = r_rem - 1'b1;
                        end
                    end
                end
                lps_pkg::OP_START: begin
                    if (!pid_vld) begin
                        status = 1'b1;
                    end else if (same_pat) begin
                        n_rep_cnt = '0;
                    end else if (!r_act_vld || (i_pid_rank >= i_hdr_cur.rank)) begin
                        n_phase_on  = 1'b0;
                        n_pulse_idx = '0;
                        n_rep_cnt   = '0;
                        n_act_vld   = 1'b1;
                        n_act_idx   = pid_idx;
                        n_rem       = (i_start_delay == '0) ? lps_pkg::TIME_W'(1)
                                                            : i_start_delay;
                        n_run       = 1'b1;
                    end
                end
                lps_pkg::OP_STOP: begin
                    if (same_pat) begin
                        n_run     = 1'b0;
                        n_rem     = '0;
                        n_act_vld = 1'b0;
                    end
                end
                lps_pkg::OP_WR_PULSE: begin
                    o_wr.pulse_we = pid_vld && (32'(i_item.pulse_slot) < PULSES_PER_PATTERN);
                end
                lps_pkg::OP_WR_HEADER: begin
                    o_wr.hdr_we = pid_vld;
                end
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld   <= 1'b0;
            r_act_idx   <= '0;
            r_phase_on  <= 1'b0;
            r_pulse_idx <= '0;
            r_rep_cnt   <= '0;
            r_rem       <= '0;
            r_run       <= 1'b0;
            r_led       <= 1'b0;
        end else begin
            r_act_vld   <= n_act_vld;
            r_act_idx   <= n_act_idx;
            r_phase_on  <= n_phase_on;
            r_pulse_idx <= n_pulse_idx;
            r_rep_cnt   <= n_rep_cnt;
            r_rem       <= n_rem;
            r_run       <= n_run;
            r_led       <= n_led;
        end
    end

    // Table prefetch follows the next state
    assign o_rd_pat   = n_act_idx;
    assign o_rd_pulse = n_pulse_idx;

    // Status after this beat
    always_comb begin
        o_res.led_on          = n_led;
        o_res.busy_res        = n_act_vld;
        o_res.current_pattern = n_act_vld ? lps_pkg::ID_W'(n_act_idx)
                                          : lps_pkg::ID_W'(PATTERN_SLOTS);
        o_res.pulse_position  = lps_pkg::SLOT_W'(n_pulse_idx);
        o_res.repeats_done    = n_rep_cnt;
        o_res.start_status    = status;
        o_res.finished        = done;
    end

endmodule

`default_nettype wire

// ===== design/led_pattern_sequencer_unit.sv =====
// LED pattern sequencer.
// i_item carries commands: millisecond tick, start, stop, pulse write and
// pattern header write. Every command beat gives exactly one status beat on
// o_res (LED level, running pattern, pulse position, repeats, flags).
// i_cfg writes the start delay register; it is ready whenever reset is
// released and should only be written while no command is in flight.
// Each command passes the input register, the core and the output register.
// Throughput: one command per cycle while o_res is ready. The pulse and
// header tables are read ahead at the address the new state points to, so
// each command needs only one registered table read plus a few compares.
// When o_res stalls, one command is held in the input register and the
// status beat waits in the output register; i_item.ready drops when both
// are full and o_res.ready is low, and stays low while reset is held.
// Reset (synchronous, active low) drops any pattern, stops the timer, turns
// the LED off and sets the start delay to 100 ms. The pulse and header
// tables are not cleared; no clearing pass is run.
`default_nettype none

module led_pattern_sequencer_unit #(
    parameter int PATTERN_SLOTS      = lps_pkg::PATTERN_SLOTS_DEF,
    parameter int PULSES_PER_PATTERN = lps_pkg::PULSES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lps_item_if.sink    i_item,
    lps_res_if.source   o_res,
    lps_cfg_if.sink     i_cfg
);

    localparam int SW = lps_pkg::idx_width(PATTERN_SLOTS);
    localparam int PW = lps_pkg::idx_width(PULSES_PER_PATTERN);

    logic                        r_in_vld;
    lps_pkg::t_item              r_in;
    logic                        r_out_vld;
    lps_pkg::t_result            r_out;
    logic [lps_pkg::TIME_W-1:0]  r_delay;

    logic                        fire;
    logic                        in_ready;
    logic                        in_take;
    lps_pkg::t_item              item_in;
    lps_pkg::t_wr_cmd            wr;
    lps_pkg::t_result            res;
    lps_pkg::t_pulse             pulse_cur;
    lps_pkg::t_header            hdr_cur;
    logic [lps_pkg::PRIO_W-1:0]  pid_rank;
    logic [SW-1:0]               rd_pat;
    logic [PW-1:0]               rd_pulse;

    // Handshake
    assign fire     = i_rst_n && r_in_vld && (!r_out_vld || o_res.ready);
    assign in_ready = i_rst_n && (!r_in_vld || fire);
    assign in_take  = i_item.valid && in_ready;
    assign i_item.ready = in_ready;
    assign i_cfg.ready  = i_rst_n;

    assign item_in.opcode           = i_item.opcode;
    assign item_in.pattern_id       = i_item.pattern_id;
    assign item_in.pulse_slot       = i_item.pulse_slot;
    assign item_in.on_time_ms       = i_item.on_time_ms;
    assign item_in.off_time_ms      = i_item.off_time_ms;
    assign item_in.pulse_count      = i_item.pulse_count;
    assign item_in.repeat_limit     = i_item.repeat_limit;
    assign item_in.pattern_priority = i_item.pattern_priority;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= item_in;
        end
    end

    // Start delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= lps_pkg::START_DELAY_RESET;
        end else if (i_cfg.valid) begin
            r_delay <= i_cfg.start_delay_ms;
        end
    end

    lps_pulse_mem #(
        .PATTERN_SLOTS      (PATTERN_SLOTS),
        .PULSES_PER_PATTERN (PULSES_PER_PATTERN)
    ) u_pulse_mem (
        .i_clk      (i_clk),
        .i_wr       (wr),
        .i_rd_pat   (rd_pat),
        .i_rd_pulse (rd_pulse),
        .o_rd       (pulse_cur)
    );

    lps_hdr_mem #(
        .PATTERN_SLOTS (PATTERN_SLOTS)
    ) u_hdr_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_a    (rd_pat),
        .i_rd_b_en (in_take),
        .i_rd_b    (i_item.pattern_id),
        .o_rd_a    (hdr_cur),
        .o_rank_b  (pid_rank)
    );

    lps_core #(
        .PATTERN_SLOTS      (PATTERN_SLOTS),
        .PULSES_PER_PATTERN (PULSES_PER_PATTERN)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_start_delay (r_delay),
        .i_pulse       (pulse_cur),
        .i_hdr_cur     (hdr_cur),
        .i_pid_rank    (pid_rank),
        .o_wr          (wr),
        .o_res         (res),
        .o_rd_pat      (rd_pat),
        .o_rd_pulse    (rd_pulse)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.led_on          = r_out.led_on;
    assign o_res.busy_res        = r_out.busy_res;
    assign o_res.current_pattern = r_out.current_pattern;
    assign o_res.pulse_position  = r_out.pulse_position;
    assign o_res.repeats_done    = r_out.repeats_done;
    assign o_res.start_status    = r_out.start_status;
    assign o_res.finished        = r_out.finished;

    // Checks
    a_finish_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.finished) |-> !o_res.busy_res)
        else $error("finished beat still reports a running pattern");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.start_status) |-> !o_res.finished)
        else $error("start error and finish flagged on one beat");

    a_ready_only_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_in_vld && r_out_vld && !o_res.ready))
        else $error("command channel stalled without a full pipeline");

    a_fire_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed command produced no status beat");

endmodule

`default_nettype wire

// ===== sim/tb_led_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_led_pattern_sequencer_unit;
    import lps_pkg::*;

    localparam int NSLOTS  = PATTERN_SLOTS_DEF;
    localparam int NPULSES = PULSES_DEF;
    localparam logic [ID_W-1:0]     NO_PATTERN  = ID_W'(NSLOTS);
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int    RANDOM_ITEMS  = 330;
    localparam int    ROUND_ITEMS   = 60;
    localparam int    HOLD_CYCLES   = 60;
    localparam int    SETTLE_CYCLES = 4;
    localparam longint TIMEOUT_NS   = 10_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lps_item_if item_if ();
    lps_res_if  res_if ();
    lps_cfg_if  cfg_if ();

    led_pattern_sequencer_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    // Shadow of the sequencer: tables, playback state and start delay
    logic [TIME_W-1:0] on_tab   [NSLOTS][NPULSES];
    logic [TIME_W-1:0] off_tab  [NSLOTS][NPULSES];
    logic [CNT_W-1:0]  len_tab  [NSLOTS];
    logic [REP_W-1:0]  rep_tab  [NSLOTS];
    logic [PRIO_W-1:0] rank_tab [NSLOTS];
    bit                pulse_known [NSLOTS][NPULSES];
    bit                hdr_known   [NSLOTS];

    logic [ID_W-1:0]   cur_pat     = NO_PATTERN;
    logic              in_on_phase = 1'b0;
    logic [4:0]        pulse_idx   = '0;
    logic [REP_W-1:0]  rep_cnt     = '0;
    logic [TIME_W-1:0] tmr_left    = '0;
    logic              tmr_run     = 1'b0;
    logic              led_lvl     = 1'b0;
    logic [TIME_W-1:0] delay_reg   = START_DELAY_RESET;

    t_result pending_status [$];
    int      mismatches     = 0;
    int      commands_sent  = 0;
    bit      sender_gaps    = 1'b1;
    bit      sink_stalls    = 1'b1;
    bit      hold_req       = 1'b0;

    // Pulse count as played: zero means one, capped at the table depth
    function automatic int span(input logic [CNT_W-1:0] n);
        if (n == 0) return 1;
        if (n > NPULSES) return NPULSES;
        return n;
    endfunction

    function automatic void load_timer(input logic [TIME_W-1:0] ms);
        tmr_left = (ms == 0) ? TIME_W'(1) : ms;
        tmr_run  = 1'b1;
    endfunction

    // Timer expiry: play the next phase, returns 1 when the pattern ends
    function automatic logic step_phase();
        logic [TIME_W-1:0] on_ms, off_ms;
        logic armed, done;
        armed = 1'b0;
        done  = 1'b0;
        if (cur_pat == NO_PATTERN) return 1'b0;
        if (pulse_idx >= NPULSES) pulse_idx = '0;
        on_ms  = on_tab[cur_pat][pulse_idx[3:0]];
        off_ms = off_tab[cur_pat][pulse_idx[3:0]];
        if (!in_on_phase && on_ms != 0) begin
            led_lvl = 1'b1;
            load_timer(on_ms);
            armed = 1'b1;
            in_on_phase = 1'b1;
        end else begin
            if (off_ms != 0) begin
                led_lvl = 1'b0;
                load_timer(off_ms);
                armed = 1'b1;
            end
            in_on_phase = 1'b0;
            pulse_idx++;
        end
        if (pulse_idx >= span(len_tab[cur_pat])) begin
            pulse_idx = '0;
            if (rep_tab[cur_pat] != REPEAT_FOREVER) begin
                rep_cnt++;
                if (rep_cnt >= rep_tab[cur_pat]) begin
                    rep_cnt = '0;
                    cur_pat = NO_PATTERN;
                    done = 1'b1;
                end
            end
        end
        // nothing played and still running: try again next tick
        if (cur_pat != NO_PATTERN && !armed) load_timer(TIME_W'(1));
        return done;
    endfunction

    // Apply one command to the shadow state, return its status beat
    function automatic t_result predict_status(input t_item c);
        t_result r;
        logic [ID_W-1:0] pid;
        logic status, done;
        status = 1'b0;
        done   = 1'b0;
        pid    = (c.pattern_id < NSLOTS) ? c.pattern_id : NO_PATTERN;
        case (c.opcode)
            OP_TICK: begin
                if (tmr_run) begin
                    if (tmr_left <= 1) begin
                        tmr_left = '0;
                        tmr_run  = 1'b0;
                        done = step_phase();
                    end else begin
                        tmr_left--;
                    end
                end
            end
            OP_START: begin
                if (pid == NO_PATTERN) begin
                    status = 1'b1;
                end else if (pid == cur_pat) begin
                    rep_cnt = '0;
                end else if (cur_pat == NO_PATTERN || rank_tab[pid] >= rank_tab[cur_pat]) begin
                    in_on_phase = 1'b0;
                    pulse_idx = '0;
                    rep_cnt = '0;
                    cur_pat = pid;
                    load_timer(delay_reg);
                end
            end
            OP_STOP: begin
                if (pid == cur_pat) begin
                    tmr_run  = 1'b0;
                    tmr_left = '0;
                    cur_pat  = NO_PATTERN;
                end
            end
            OP_WR_PULSE: begin
                if (pid != NO_PATTERN) begin
                    on_tab[pid][c.pulse_slot]      = c.on_time_ms;
                    off_tab[pid][c.pulse_slot]     = c.off_time_ms;
                    pulse_known[pid][c.pulse_slot] = 1'b1;
                end
            end
            OP_WR_HEADER: begin
                if (pid != NO_PATTERN) begin
                    len_tab[pid]   = c.pulse_count;
                    rep_tab[pid]   = c.repeat_limit;
                    rank_tab[pid]  = c.pattern_priority;
                    hdr_known[pid] = 1'b1;
                end
            end
            default: ;
        endcase
        r.led_on          = led_lvl;
        r.busy_res        = (cur_pat != NO_PATTERN);
        r.current_pattern = cur_pat;
        r.pulse_position  = pulse_idx[3:0];
        r.repeats_done    = rep_cnt;
        r.start_status    = status;
        r.finished        = done;
        return r;
    endfunction

    // Never play pulses or a header that were not written
    function automatic bit pulses_ready(input int p, input logic [CNT_W-1:0] cnt);
        for (int i = 0; i < span(cnt); i++)
            if (!pulse_known[p][i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit runnable(input int p);
        return hdr_known[p] && pulses_ready(p, len_tab[p]);
    endfunction

    function automatic bit start_ok(input logic [ID_W-1:0] pid);
        return pid >= NSLOTS || pid == cur_pat || runnable(pid);
    endfunction

    // Random helpers: gaps mostly short, values biased to keep patterns moving
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        if ($urandom_range(0, 99) < 85) return ID_W'($urandom_range(0, NSLOTS - 1));
        return ID_W'($urandom_range(NSLOTS, 15));
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return '0;
        if (r < 85) return TIME_W'($urandom_range(1, 3));
        if (r < 96) return TIME_W'($urandom_range(4, 20));
        return TIME_W'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 65) return CNT_W'($urandom_range(1, 3));
        if (r < 80) return CNT_W'($urandom_range(4, 8));
        if (r < 88) return CNT_W'(NPULSES);
        return CNT_W'($urandom_range(NPULSES + 1, 31));
    endfunction

    function automatic logic [REP_W-1:0] rand_repeat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return REP_W'($urandom_range(0, 3));
        if (r < 85) return REPEAT_FOREVER;
        return REP_W'($urandom);
    endfunction

    function automatic logic [PRIO_W-1:0] rand_rank();
        if ($urandom_range(0, 99) < 80) return PRIO_W'($urandom_range(0, 3));
        return PRIO_W'($urandom);
    endfunction

    // Command with every field random except the opcode
    function automatic t_item blank_cmd(input logic [OPCODE_W-1:0] op);
        t_item c;
        c = t_item'({$urandom, $urandom});
        c.opcode = op;
        return c;
    endfunction

    // Send one command beat, predict its status on acceptance
    task automatic send_command(input t_item c);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid            <= 1'b1;
        item_if.opcode           <= c.opcode;
        item_if.pattern_id       <= c.pattern_id;
        item_if.pulse_slot       <= c.pulse_slot;
        item_if.on_time_ms       <= c.on_time_ms;
        item_if.off_time_ms      <= c.off_time_ms;
        item_if.pulse_count      <= c.pulse_count;
        item_if.repeat_limit     <= c.repeat_limit;
        item_if.pattern_priority <= c.pattern_priority;
        do @(posedge clk); while (item_if.ready !== 1'b1);
        pending_status.push_back(predict_status(c));
        if (c.opcode <= OP_WR_HEADER) commands_sent++;
    endtask

    task automatic issue_tick(input int n);
        repeat (n) send_command(blank_cmd(OP_TICK));
    endtask

    task automatic issue_start(input logic [ID_W-1:0] id);
        t_item c;
        c = blank_cmd(OP_START);
        c.pattern_id = id;
        send_command(c);
    endtask

    task automatic issue_stop(input logic [ID_W-1:0] id);
        t_item c;
        c = blank_cmd(OP_STOP);
        c.pattern_id = id;
        send_command(c);
    endtask

    task automatic issue_pulse(input logic [ID_W-1:0] id, input logic [SLOT_W-1:0] slot,
                               input logic [TIME_W-1:0] on_ms, input logic [TIME_W-1:0] off_ms);
        t_item c;
        c = blank_cmd(OP_WR_PULSE);
        c.pattern_id  = id;
        c.pulse_slot  = slot;
        c.on_time_ms  = on_ms;
        c.off_time_ms = off_ms;
        send_command(c);
    endtask

    task automatic issue_header(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] cnt,
                                input logic [REP_W-1:0] rep, input logic [PRIO_W-1:0] prio);
        t_item c;
        c = blank_cmd(OP_WR_HEADER);
        c.pattern_id       = id;
        c.pulse_count      = cnt;
        c.repeat_limit     = rep;
        c.pattern_priority = prio;
        send_command(c);
    endtask

    // Stop sending and wait for every outstanding status beat
    task automatic drain_status();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_start_delay(input logic [TIME_W-1:0] ms);
        drain_status();
        @(negedge clk);
        cfg_if.valid          <= 1'b1;
        cfg_if.start_delay_ms <= ms;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        delay_reg = ms;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Directed: field extremes, every opcode and the corner cases
    task automatic test_directed();
        set_start_delay('0);                       // zero delay behaves as 1 ms
        issue_header(4'd15, 5'd16, 8'd1, 8'd0);    // out of range, ignored
        issue_pulse(NO_PATTERN, 4'd15, 16'hFFFF, 16'hFFFF);
        issue_pulse(4'd0, 4'd0, 16'd0, 16'd0);     // both phases skipped
        issue_header(4'd0, 5'd0, 8'd2, 8'd0);      // count 0 plays one pulse
        send_command(blank_cmd(OP_SPARE_LO));
        send_command(blank_cmd(OP_SPARE_HI));
        issue_stop(NO_PATTERN);
        issue_start(NO_PATTERN);
        issue_start(4'd15);
        issue_start(4'd0);
        issue_tick(4);                             // stalled walk, then finish
        issue_pulse(4'd1, 4'd0, 16'd1, 16'd0);
        issue_header(4'd1, 5'd1, REPEAT_FOREVER, 8'd10);
        issue_start(4'd1);
        issue_start(4'd0);                         // lower rank, refused
        issue_tick(3);
        issue_header(4'd1, 5'd1, 8'd3, 8'd10);     // rewrite while running
        issue_tick(2);
        issue_start(4'd1);                         // restart clears repeats
        issue_pulse(4'd2, 4'd0, 16'd0, 16'd1);
        issue_header(4'd2, 5'd1, 8'd0, 8'd10);
        issue_start(4'd2);                         // equal rank takes over
        issue_tick(3);                             // finish, stale off timer
        issue_start(4'd1);
        issue_tick(2);
        issue_stop(4'd2);                          // not current, no effect
        issue_stop(4'd1);                          // LED holds its level
    endtask

    // Start delay at both ends of its range, longest pulse times
    task automatic test_delay_extremes();
        set_start_delay(16'hFFFF);
        issue_start(4'd1);
        issue_tick(5);
        issue_stop(4'd1);
        set_start_delay(16'd1);
        issue_pulse(4'd3, 4'd0, 16'hFFFF, 16'hFFFF);
        issue_pulse(4'd3, 4'd15, 16'd0, 16'hFFFF);
        issue_header(4'd3, 5'd1, REPEAT_FOREVER, 8'hFF);
        issue_start(4'd3);
        issue_tick(4);
        issue_stop(4'd3);
    endtask

    // Full-depth pattern with an oversized count, played to the end
    task automatic test_full_length();
        int guard;
        for (int i = 0; i < NPULSES; i++)
            issue_pulse(4'd7, SLOT_W'(i), TIME_W'($urandom_range(0, 2)),
                        TIME_W'($urandom_range(0, 2)));
        issue_header(4'd7, 5'd31, 8'd1, 8'hFF);
        issue_start(4'd7);
        guard = 0;
        while (cur_pat == 4'd7 && guard < 400) begin
            issue_tick(1);
            guard++;
        end
    endtask

    // Status sink held off while commands keep coming, then a full drain
    task automatic test_output_stall();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_req = 1'b1;
        issue_start(4'd1);
        issue_tick(24);
        drain_status();
    endtask

    // Random rounds: programming, start-and-run bursts and loose commands
    task automatic test_random();
        int r, goal, round, stop_at;
        logic [ID_W-1:0]  pid;
        logic [CNT_W-1:0] cnt;
        int ids [$];
        round = 0;
        stop_at = commands_sent + RANDOM_ITEMS;
        while (commands_sent < stop_at) begin
            set_start_delay(($urandom_range(0, 3) == 0) ? TIME_W'(0)
                                                        : TIME_W'($urandom_range(1, 4)));
            sender_gaps = (round % 3 != 0);
            sink_stalls = (round % 3 != 1);
            goal = commands_sent + ROUND_ITEMS;
            round++;
            while (commands_sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    // program a pattern: pulses first, then its header
                    pid = ID_W'($urandom_range(0, NSLOTS - 1));
                    cnt = rand_count();
                    for (int i = 0; i < span(cnt); i++)
                        issue_pulse(pid, SLOT_W'(i), rand_time(), rand_time());
                    issue_header(pid, cnt, rand_repeat(), rand_rank());
                end else if (r < 28) begin
                    ids.delete();
                    for (int p = 0; p < NSLOTS; p++)
                        if (runnable(p)) ids.push_back(p);
                    if (ids.size() == 0) begin
                        issue_tick(1);
                    end else begin
                        issue_start(ID_W'(ids[$urandom_range(0, ids.size() - 1)]));
                        issue_tick($urandom_range(3, 15));
                    end
                end else begin
                    r = $urandom_range(0, 19);
                    if (r < 10) begin
                        issue_tick(1);
                    end else if (r < 12) begin
                        pid = rand_id();
                        if (start_ok(pid)) issue_start(pid);
                        else issue_tick(1);
                    end else if (r < 14) begin
                        issue_stop($urandom_range(0, 1) ? cur_pat : ID_W'($urandom));
                    end else if (r < 16) begin
                        issue_pulse(rand_id(), SLOT_W'($urandom), rand_time(), rand_time());
                    end else if (r < 18) begin
                        pid = rand_id();
                        cnt = rand_count();
                        if (pid < NSLOTS && pid == cur_pat && !pulses_ready(pid, cnt))
                            issue_tick(1);
                        else
                            issue_header(pid, cnt, rand_repeat(), rand_rank());
                    end else begin
                        send_command(blank_cmd(OPCODE_W'($urandom_range(OP_SPARE_LO,
                                                                         OP_SPARE_HI))));
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
    endtask

    // Status sink: random stalls, plus a long hold-off on request
    initial begin : status_sink
        int stall_left, hold_left;
        stall_left = 0;
        hold_left  = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (sink_stalls && stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Compare each status beat with the oldest prediction
    always @(posedge clk) begin : status_check
        t_result got, want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.led_on          = res_if.led_on;
            got.busy_res        = res_if.busy_res;
            got.current_pattern = res_if.current_pattern;
            got.pulse_position  = res_if.pulse_position;
            got.repeats_done    = res_if.repeats_done;
            got.start_status    = res_if.start_status;
            got.finished        = res_if.finished;
            if (pending_status.size() == 0) begin
                $display("%0t ns: status beat with nothing expected", $time);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                if (got.led_on !== want.led_on)
                    report_mismatch("led_on", want.led_on, got.led_on);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", want.busy_res, got.busy_res);
                if (got.current_pattern !== want.current_pattern)
                    report_mismatch("current_pattern", want.current_pattern,
                                    got.current_pattern);
                if (got.pulse_position !== want.pulse_position)
                    report_mismatch("pulse_position", want.pulse_position, got.pulse_position);
                if (got.repeats_done !== want.repeats_done)
                    report_mismatch("repeats_done", want.repeats_done, got.repeats_done);
                if (got.start_status !== want.start_status)
                    report_mismatch("start_status", want.start_status, got.start_status);
                if (got.finished !== want.finished)
                    report_mismatch("finished", want.finished, got.finished);
            end
        end
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    initial begin
        item_if.valid            = 1'b0;
        item_if.opcode           = '0;
        item_if.pattern_id       = '0;
        item_if.pulse_slot       = '0;
        item_if.on_time_ms       = '0;
        item_if.off_time_ms      = '0;
        item_if.pulse_count      = '0;
        item_if.repeat_limit     = '0;
        item_if.pattern_priority = '0;
        cfg_if.valid             = 1'b0;
        cfg_if.start_delay_ms    = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_delay_extremes();
        test_full_length();
        test_output_stall();
        test_random();
        drain_status();

        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
